FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property on the module clock that must hold at every edge outside reset.
`define BMPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold whenever the condition is true.
`define BMPD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

FILE: rtl/bmpd_pkg.sv
package bmpd_pkg;

    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;
    localparam int unsigned WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned CFG_W      = 16;

    // Configuration register indexes.
    localparam logic CFG_DEST_X = 1'b0;
    localparam logic CFG_DEST_Y = 1'b1;

    // Result kinds.
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIG   = 2'd1;
    localparam logic [1:0] STATUS_BAD_FMT   = 2'd2;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd3;

    // Header byte positions at which a field is complete.
    localparam logic [31:0] HDR_SIG_END    = 32'd1;
    localparam logic [31:0] HDR_OFFSET_END = 32'd13;
    localparam logic [31:0] HDR_WIDTH_END  = 32'd21;
    localparam logic [31:0] HDR_HEIGHT_END = 32'd25;
    localparam logic [31:0] HDR_PLANES_END = 32'd27;
    localparam logic [31:0] HDR_DEPTH_END  = 32'd29;
    localparam logic [31:0] HDR_LAST       = 32'd33;
    localparam logic [31:0] HDR_LEN        = 32'd34;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;
    localparam logic [7:0]  RED_MASK      = 8'hF8;
    localparam logic [7:0]  GREEN_MASK    = 8'hFC;

    // One file byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       start;
    } t_in_item;

endpackage

FILE: rtl/bmpd_in_if.sv
interface bmpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       start_file;

    modport source (output valid, output byte_in, output start_file, input ready);
    modport sink   (input valid, input byte_in, input start_file, output ready);
endinterface

FILE: rtl/bmpd_out_if.sv
interface bmpd_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         status_code;
    logic [15:0]        pixel_rgb565;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               last_pixel;

    modport source (output valid, output kind, output status_code, output pixel_rgb565,
                    output screen_x, output screen_y, output last_pixel, input ready);
    modport sink   (input valid, input kind, input status_code, input pixel_rgb565,
                    input screen_x, input screen_y, input last_pixel, output ready);
endinterface

FILE: rtl/bmpd_in_reg.sv
module bmpd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bmpd_in_if.sink           i_in,
    input  logic              i_take,
    output bmpd_pkg::t_in_item o_item
);
    import bmpd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_start;

    // The register frees up in the same cycle that the decoder takes its byte.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data  <= i_in.byte_in;
            r_start <= i_in.start_file;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;
    assign o_item.start = r_start;
endmodule

FILE: rtl/bmpd_decode.sv
`include "assert_macros.svh"

module bmpd_decode (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bmpd_pkg::t_in_item       i_item,
    output logic                     o_take,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [bmpd_pkg::CFG_W-1:0] i_cfg_data,
    bmpd_out_if.source               o_out
);
    import bmpd_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_PAD    = 3'd4;

    logic signed [COORD_W-1:0] r_dest_x, r_dest_y;

    logic [2:0]          r_phase,    n_phase;
    logic [31:0]         r_count,    n_count;
    logic [31:0]         r_shift,    n_shift;
    logic [31:0]         r_offset,   n_offset;
    logic [WIDTH_W-1:0]  r_width,    n_width;
    logic [HEIGHT_W-1:0] r_height,   n_height;
    logic [WIDTH_W-1:0]  r_col,      n_col;
    logic [HEIGHT_W-1:0] r_row,      n_row;
    logic [1:0]          r_chan,     n_chan;
    logic [4:0]          r_blue,     n_blue;
    logic [5:0]          r_green,    n_green;
    logic [1:0]          r_pad,      n_pad;
    logic                r_fmt_bad,  n_fmt_bad;
    logic                r_size_bad, n_size_bad;

    logic                r_out_valid;
    logic                r_kind;
    logic [1:0]          r_code;
    logic [15:0]         r_pix;
    logic [COORD_W-1:0]  r_x, r_y;
    logic                r_last;

    logic                res_valid, res_kind, res_last;
    logic [1:0]          res_code;
    logic [15:0]         res_pix;
    logic [COORD_W-1:0]  res_x, res_y;

    logic                pixel_go;
    logic [7:0]          red_m, green_m;

    logic                in_image;
    logic                out_status;
    logic                pix_clear;

    assign o_take  = i_item.valid && (!r_out_valid || o_out.ready);
    assign red_m   = i_item.data & RED_MASK;
    assign green_m = i_item.data & GREEN_MASK;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_shift    = r_shift;
        n_offset   = r_offset;
        n_width    = r_width;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        n_chan     = r_chan;
        n_blue     = r_blue;
        n_green    = r_green;
        n_pad      = r_pad;
        n_fmt_bad  = r_fmt_bad;
        n_size_bad = r_size_bad;
        res_valid  = 1'b0;
        res_kind   = KIND_PIXEL;
        res_code   = STATUS_OK;
        res_pix    = '0;
        res_x      = '0;
        res_y      = '0;
        res_last   = 1'b0;
        pixel_go   = 1'b0;

        if (o_take) begin
            // A start flag abandons whatever file was in progress.
            if (i_item.start) begin
                n_phase    = PH_HEADER;
                n_count    = '0;
                n_shift    = '0;
                n_offset   = '0;
                n_width    = '0;
                n_height   = '0;
                n_col      = '0;
                n_row      = '0;
                n_chan     = '0;
                n_blue     = '0;
                n_green    = '0;
                n_pad      = '0;
                n_fmt_bad  = 1'b0;
                n_size_bad = 1'b0;
            end

            unique case (n_phase)
                PH_HEADER: begin
                    n_shift = {i_item.data, n_shift[31:8]};
                    unique case (n_count)
                        HDR_SIG_END: begin
                            if (n_shift[31:16] != BMP_SIGNATURE) begin
                                n_phase   = PH_IDLE;
                                res_valid = 1'b1;
                                res_kind  = KIND_STATUS;
                                res_code  = STATUS_BAD_SIG;
                            end
                        end
                        HDR_OFFSET_END: begin
                            n_offset = n_shift;
                            if (n_shift < HDR_LEN) n_size_bad = 1'b1;
                        end
                        HDR_WIDTH_END: begin
                            n_width = n_shift[WIDTH_W-1:0];
                            if (n_shift == '0 || n_shift > 32'(MAX_WIDTH)) n_size_bad = 1'b1;
                        end
                        HDR_HEIGHT_END: begin
                            n_height = n_shift[HEIGHT_W-1:0];
                            if (n_shift > 32'(MAX_HEIGHT)) n_size_bad = 1'b1;
                        end
                        HDR_PLANES_END: begin
                            if (n_shift[31:16] != BMP_PLANES) n_fmt_bad = 1'b1;
                        end
                        HDR_DEPTH_END: begin
                            if (n_shift[31:16] != BMP_DEPTH) n_fmt_bad = 1'b1;
                        end
                        HDR_LAST: begin
                            if (n_shift != '0) n_fmt_bad = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = KIND_STATUS;
                            if (n_fmt_bad) begin
                                res_code = STATUS_BAD_FMT;
                                n_phase  = PH_IDLE;
                            end else if (n_size_bad) begin
                                res_code = STATUS_BAD_SIZE;
                                n_phase  = PH_IDLE;
                            end else begin
                                res_code = STATUS_OK;
                                n_phase  = (n_height == '0) ? PH_IDLE : PH_SKIP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_count = n_count + 32'd1;
                end
                PH_SKIP: begin
                    if (n_count < n_offset) begin
                        n_count = n_count + 32'd1;
                    end else begin
                        n_phase  = PH_PIXEL;
                        pixel_go = 1'b1;
                    end
                end
                PH_PIXEL: begin
                    pixel_go = 1'b1;
                end
                PH_PAD: begin
                    if (n_pad != 2'd0) n_pad = n_pad - 2'd1;
                    if (n_pad == 2'd0) n_phase = PH_PIXEL;
                end
                default: begin
                end
            endcase

            if (pixel_go) begin
                if (n_chan == 2'd0) begin
                    n_blue = i_item.data[7:3];
                    n_chan = 2'd1;
                end else if (n_chan == 2'd1) begin
                    n_green = green_m[7:2];
                    n_chan  = 2'd2;
                end else begin
                    n_chan    = 2'd0;
                    res_valid = 1'b1;
                    res_kind  = KIND_PIXEL;
                    res_pix   = {red_m[7:3], n_green, n_blue};
                    res_x     = r_dest_x + COORD_W'(n_col);
                    res_y     = r_dest_y + COORD_W'(n_height) - COORD_W'(1) - COORD_W'(n_row);
                    if ({1'b0, n_col} + (WIDTH_W+1)'(1) >= {1'b0, n_width}) begin
                        n_col = '0;
                        if ({1'b0, n_row} + (HEIGHT_W+1)'(1) >= {1'b0, n_height}) begin
                            res_last = 1'b1;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_row   = n_row + HEIGHT_W'(1);
                            // Rows pad to four bytes; three bytes a pixel leaves width mod 4.
                            n_pad   = n_width[1:0];
                            n_phase = (n_pad != 2'd0) ? PH_PAD : PH_PIXEL;
                        end
                    end else begin
                        n_col = n_col + WIDTH_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_offset   <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_chan     <= '0;
            r_pad      <= '0;
            r_fmt_bad  <= 1'b0;
            r_size_bad <= 1'b0;
            r_dest_x   <= '0;
            r_dest_y   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_offset   <= n_offset;
            r_width    <= n_width;
            r_height   <= n_height;
            r_col      <= n_col;
            r_row      <= n_row;
            r_chan     <= n_chan;
            r_pad      <= n_pad;
            r_fmt_bad  <= n_fmt_bad;
            r_size_bad <= n_size_bad;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEST_X: r_dest_x <= i_cfg_data;
                    CFG_DEST_Y: r_dest_y <= i_cfg_data;
                    default:    r_dest_x <= r_dest_x;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_blue  <= n_blue;
        r_green <= n_green;
    end

    // Result register: loads when a byte is taken, empties when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && res_valid) begin
            r_kind <= res_kind;
            r_code <= res_code;
            r_pix  <= res_pix;
            r_x    <= res_x;
            r_y    <= res_y;
            r_last <= res_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.status_code  = r_code;
    assign o_out.pixel_rgb565 = r_pix;
    assign o_out.screen_x     = r_x;
    assign o_out.screen_y     = r_y;
    assign o_out.last_pixel   = r_last;

    assign in_image   = (r_phase == PH_PIXEL) || (r_phase == PH_PAD);
    assign out_status = r_out_valid && (r_kind == KIND_STATUS);
    assign pix_clear  = (r_pix == '0) && (r_x == '0) && (r_y == '0) && !r_last;

    `BMPD_ASSERT(a_chan_range, r_chan != 2'd3, "channel index out of range")
    `BMPD_ASSERT_IMP(a_col_bound, in_image, r_col < r_width, "column beyond image width")
    `BMPD_ASSERT_IMP(a_row_bound, in_image, r_row < r_height, "row beyond image height")
    `BMPD_ASSERT_IMP(a_pad_nonzero, r_phase == PH_PAD, r_pad != 2'd0, "padding with none left")
    `BMPD_ASSERT_IMP(a_status_clean, out_status, pix_clear, "status carries pixel fields")
endmodule

FILE: rtl/bmp24_to_rgb565_stream_decoder_unit.sv
// Streaming BMP decoder: takes a 24-bit uncompressed BMP file one byte per request
// (start_file marks byte 0), checks the 34-byte header and answers it with one status
// result, then emits one RGB565 pixel with screen coordinates for every B,G,R triple,
// rows bottom-up from dest_y + height - 1, skipping the data-offset gap and row padding.
// One byte is taken every clock cycle as long as the sink keeps up. An accepted byte
// waits in the input register, and its result is then held in the result register.
// While a result waits for the sink the decoder takes no byte; one more byte fits in
// the input register and then the input stalls. The user must write dest_x and dest_y
// only while idle; the block itself does not enforce it.
module bmp24_to_rgb565_stream_decoder_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bmpd_in_if.sink                    i_in,
    bmpd_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [bmpd_pkg::CFG_W-1:0] i_cfg_data
);
    import bmpd_pkg::*;

    t_in_item item;
    logic     take;

    bmpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_item  (item)
    );

    bmpd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .o_take      (take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bmpd_pkg::*;

    typedef logic [7:0] t_u8;

    typedef struct packed {
        logic        kind;
        logic [1:0]  code;
        logic [15:0] rgb;
        logic [15:0] sx;
        logic [15:0] sy;
        logic        last;
    } t_dec_out;

    typedef enum logic [2:0] {
        WAIT_START, IN_HEADER, IN_GAP, IN_PIXELS, IN_PADDING
    } t_dec_phase;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_BYTES = 100;

    class bmp_decode_scoreboard;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        t_dec_phase  phase;
        logic [31:0] byte_cnt, hdr_shift, data_off, img_w, img_h, col, row;
        logic [1:0]  chan, pad_left;
        logic [7:0]  blue, green;
        bit          fmt_bad;
        t_dec_out    decoded_q[$];
        int          errors, checked, pixels, bytes_in;
        int          statuses[4];

        function new();
            dest_x   = '0;
            dest_y   = '0;
            phase    = WAIT_START;
            errors   = 0;
            checked  = 0;
            pixels   = 0;
            bytes_in = 0;
            foreach (statuses[i]) statuses[i] = 0;
            clear_file();
        endfunction

        function void clear_file();
            byte_cnt  = '0;
            hdr_shift = '0;
            data_off  = '0;
            img_w     = '0;
            img_h     = '0;
            col       = '0;
            row       = '0;
            chan      = '0;
            pad_left  = '0;
            blue      = '0;
            green     = '0;
            fmt_bad   = 1'b0;
        endfunction

        function void queue_status(logic [1:0] code);
            t_dec_out r;
            r      = '0;
            r.kind = KIND_STATUS;
            r.code = code;
            decoded_q.push_back(r);
        endfunction

        function void take_pixel_byte(t_u8 b);
            t_dec_out r;
            if (chan == 2'd0) begin
                blue = b;
                chan = 2'd1;
            end else if (chan == 2'd1) begin
                green = b;
                chan  = 2'd2;
            end else begin
                chan   = 2'd0;
                r.kind = KIND_PIXEL;
                r.code = STATUS_OK;
                r.rgb  = {b[7:3], green[7:2], blue[7:3]};
                r.sx   = dest_x + col[15:0];
                // Rows arrive bottom-up, so the first row lands on the bottom screen line.
                r.sy   = dest_y + img_h[15:0] - 16'd1 - row[15:0];
                r.last = 1'b0;
                if (col + 1 >= img_w) begin
                    col = '0;
                    if (row + 1 >= img_h) begin
                        r.last = 1'b1;
                        phase  = WAIT_START;
                    end else begin
                        row++;
                        pad_left = 2'((4 - (img_w * 3) % 4) % 4);
                        phase    = (pad_left != 0) ? IN_PADDING : IN_PIXELS;
                    end
                end else begin
                    col++;
                end
                decoded_q.push_back(r);
            end
        endfunction

        function void decode_byte(t_u8 b, bit first);
            logic [31:0] idx;
            bytes_in++;
            if (first) begin
                clear_file();
                phase = IN_HEADER;
            end
            case (phase)
                IN_HEADER: begin
                    idx       = byte_cnt;
                    hdr_shift = {b, hdr_shift[31:8]};
                    byte_cnt++;
                    case (idx)
                        HDR_SIG_END: begin
                            if (hdr_shift[31:16] != BMP_SIGNATURE) begin
                                phase = WAIT_START;
                                queue_status(STATUS_BAD_SIG);
                            end
                        end
                        HDR_OFFSET_END: data_off = hdr_shift;
                        HDR_WIDTH_END:  img_w = hdr_shift;
                        HDR_HEIGHT_END: img_h = hdr_shift;
                        HDR_PLANES_END: if (hdr_shift[31:16] != BMP_PLANES) fmt_bad = 1'b1;
                        HDR_DEPTH_END:  if (hdr_shift[31:16] != BMP_DEPTH) fmt_bad = 1'b1;
                        HDR_LAST: begin
                            if (hdr_shift != 0) fmt_bad = 1'b1;
                            phase = WAIT_START;
                            if (fmt_bad) begin
                                queue_status(STATUS_BAD_FMT);
                            end else if (data_off < HDR_LEN || img_w == 0 ||
                                         img_w > MAX_WIDTH || img_h > MAX_HEIGHT) begin
                                queue_status(STATUS_BAD_SIZE);
                            end else begin
                                queue_status(STATUS_OK);
                                if (img_h != 0) phase = IN_GAP;
                            end
                        end
                        default: ;
                    endcase
                end
                IN_GAP: begin
                    if (byte_cnt < data_off) begin
                        byte_cnt++;
                    end else begin
                        phase = IN_PIXELS;
                        take_pixel_byte(b);
                    end
                end
                IN_PIXELS: take_pixel_byte(b);
                IN_PADDING: begin
                    if (pad_left > 0) pad_left--;
                    if (pad_left == 0) phase = IN_PIXELS;
                end
                default: ;
            endcase
        endfunction

        function void compare_output(t_dec_out got);
            t_dec_out want;
            checked++;
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d with none due: kind %0d code %0d rgb %h",
                             checked, got.kind, got.code, got.rgb);
                return;
            end
            want = decoded_q.pop_front();
            if (want.kind == KIND_PIXEL) pixels++;
            else statuses[want.code]++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0d exp/act: kind %0d/%0d code %0d/%0d rgb %h/%h",
                             checked, want.kind, got.kind, want.code, got.code,
                             want.rgb, got.rgb);
                    $display("       x %0d/%0d y %0d/%0d last %0d/%0d",
                             $signed(want.sx), $signed(got.sx),
                             $signed(want.sy), $signed(got.sy), want.last, got.last);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    bmpd_in_if  in_ch ();
    bmpd_out_if out_ch ();

    bmp24_to_rgb565_stream_decoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    bmp_decode_scoreboard sb = new();

    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;
    bit hold_req     = 1'b0;
    int quiet        = 0;
    int files_sent   = 0;
    int origins      = 0;
    int random_bytes = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Result side: random stalls, bursts without stalls, and one long hold on request.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            sb.compare_output({out_ch.kind, out_ch.status_code, out_ch.pixel_rgb565,
                               out_ch.screen_x, out_ch.screen_y, out_ch.last_pixel});
        end
    end

    task automatic send_byte(input t_u8 b, input bit first);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_in    <= b;
        in_ch.start_file <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.decode_byte(b, first);
    endtask

    task automatic send_file(ref t_u8 q[$], input bit fast);
        files_sent++;
        tx_burst = fast || ($urandom_range(0, 3) == 0);
        foreach (q[i]) send_byte(q[i], i == 0);
    endtask

    // Drop valid and wait until every due result has come out of the block.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_dest(input logic [15:0] x, input logic [15:0] y);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEST_X;
        cfg_data  <= x;
        @(posedge i_clk);
        cfg_index <= CFG_DEST_Y;
        cfg_data  <= y;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.dest_x = x;
        sb.dest_y = y;
        origins++;
    endtask

    function automatic void push_le(ref t_u8 q[$], input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void make_header(ref t_u8 q[$], input logic [15:0] sig,
                                        input logic [31:0] off, input logic [31:0] wid,
                                        input logic [31:0] hgt, input logic [15:0] pln,
                                        input logic [15:0] dep, input logic [31:0] cmp);
        q.delete();
        push_le(q, sig, 2);
        push_le(q, $urandom, 4);
        push_le(q, $urandom, 4);
        push_le(q, off, 4);
        push_le(q, $urandom, 4);
        push_le(q, wid, 4);
        push_le(q, hgt, 4);
        push_le(q, pln, 2);
        push_le(q, dep, 2);
        push_le(q, cmp, 4);
    endfunction

    function automatic t_u8 pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'hF8;
            3:       return 8'h07;
            4:       return 8'hFC;
            5:       return 8'h03;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void good_file(ref t_u8 q[$], input int w, input int h, input int off);
        int pad;
        make_header(q, BMP_SIGNATURE, off, w, h, BMP_PLANES, BMP_DEPTH, 32'd0);
        pad = (4 - (w * 3) % 4) % 4;
        repeat (off - HDR_LEN) q.push_back(8'($urandom));
        for (int r = 0; r < h; r++) begin
            repeat (w * 3) q.push_back(pick_channel());
            repeat (pad) q.push_back(8'($urandom));
        end
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_u8         q[$];
        int          sel, w, h;
        logic [31:0] off, wid, hgt, cmp;
        logic [15:0] sig, pln, dep;

        in_ch.valid      <= 1'b0;
        in_ch.byte_in    <= '0;
        in_ch.start_file <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_DEST_X;
        cfg_data         <= '0;
        do @(posedge i_clk); while (!i_rst_n);

        // Bytes before any start flag are ignored.
        repeat (3) send_byte(8'($urandom), 1'b0);

        // A bad signature is answered after byte 1, so a short file is enough.
        make_header(q, 16'h4D43, 34, 1, 1, BMP_PLANES, BMP_DEPTH, 0);
        while (q.size() > 4) void'(q.pop_back());
        send_file(q, 0);
        make_header(q, 16'h5A42, 34, 1, 1, BMP_PLANES, BMP_DEPTH, 0);
        while (q.size() > 4) void'(q.pop_back());
        send_file(q, 0);

        // Header rejections, one field at a time but for one header with zero width and two planes.
        make_header(q, BMP_SIGNATURE, 34, 1, 1, 16'd0, BMP_DEPTH, 0);  send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, 0, 1, 16'd2, BMP_DEPTH, 0);  send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, 1, 1, BMP_PLANES, 16'd32, 0); send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, 1, 1, BMP_PLANES, BMP_DEPTH, 32'h8000_0000);
        send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 33, 1, 1, BMP_PLANES, BMP_DEPTH, 0);  send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, 0, 1, BMP_PLANES, BMP_DEPTH, 0);  send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, MAX_WIDTH + 1, 1, BMP_PLANES, BMP_DEPTH, 0);
        send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 34, 1, MAX_HEIGHT + 1, BMP_PLANES, BMP_DEPTH, 0);
        send_file(q, 0);
        // A negative (top-down) height reads as a huge unsigned value.
        make_header(q, BMP_SIGNATURE, 34, 2, 32'hFFFF_FFFE, BMP_PLANES, BMP_DEPTH, 0);
        send_file(q, 0);

        // Accepted headers that produce no pixels: zero height, and an offset past the data.
        make_header(q, BMP_SIGNATURE, 34, 3, 0, BMP_PLANES, BMP_DEPTH, 0);
        repeat (6) q.push_back(8'($urandom));
        send_file(q, 0);
        make_header(q, BMP_SIGNATURE, 32'hFFFF_FFFF, 3, 2, BMP_PLANES, BMP_DEPTH, 0);
        repeat (12) q.push_back(8'($urandom));
        send_file(q, 0);

        // Small images over every nonzero padding amount, at the wrapping corner.
        set_dest(16'h7FFF, 16'h7FFF);
        good_file(q, 1, 1, 34); repeat (4) q.push_back(8'($urandom)); send_file(q, 0);
        good_file(q, 3, 2, 40); send_file(q, 0);
        good_file(q, 2, 2, 34); send_file(q, 0);

        // A new start abandons a file mid-image and mid-header.
        set_dest(16'h8000, 16'h8000);
        good_file(q, 4, 3, 34); send_file(q, 0);
        good_file(q, 6, 4, 34);
        while (q.size() > 54) void'(q.pop_back());
        send_file(q, 0);
        good_file(q, 2, 3, 34);
        while (q.size() > 20) void'(q.pop_back());
        send_file(q, 0);
        good_file(q, 1, 2, 36); send_file(q, 0);

        // Widest image while the result side holds off, so the input backs up.
        // Only the first pixels of the largest images are sent; the next start drops them.
        set_dest(16'h8000, 16'h7FFF);
        hold_req = 1'b1;
        good_file(q, MAX_WIDTH, 1, 34);
        while (q.size() > HDR_LEN + 24) void'(q.pop_back());
        send_file(q, 1);

        set_dest(16'hFFFF, 16'h0001);
        good_file(q, 1, MAX_HEIGHT, 34);
        while (q.size() > HDR_LEN + 16) void'(q.pop_back());
        send_file(q, 0);

        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 5) == 0) set_dest(pick_coord(), pick_coord());
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
                good_file(q, w, h, HDR_LEN + $urandom_range(0, 8));
                if ($urandom_range(0, 7) == 0) begin
                    sel = $urandom_range(1, q.size() - 1);
                    while (q.size() > sel) void'(q.pop_back());
                end
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
            end else if (sel < 85) begin
                sig = BMP_SIGNATURE;
                off = HDR_LEN;
                wid = $urandom_range(1, 8);
                hgt = $urandom_range(1, 4);
                pln = BMP_PLANES;
                dep = BMP_DEPTH;
                cmp = '0;
                case ($urandom_range(0, 8))
                    0: begin sig = $urandom; if (sig == BMP_SIGNATURE) sig[0] = ~sig[0]; end
                    1: begin pln = $urandom; if (pln == BMP_PLANES) pln = 16'd0; end
                    2: begin dep = $urandom_range(0, 64); if (dep == BMP_DEPTH) dep = 16'd32; end
                    3: begin cmp = $urandom; if (cmp == 0) cmp = 32'd1; end
                    4: off = $urandom_range(0, HDR_LEN - 1);
                    5: wid = '0;
                    6: wid = $urandom_range(0, 1) ? MAX_WIDTH + $urandom_range(1, 8)
                                                  : $urandom | 32'h0000_1000;
                    7: hgt = $urandom_range(0, 1) ? MAX_HEIGHT + $urandom_range(1, 8)
                                                  : $urandom | 32'h0000_1000;
                    default: off = $urandom | 32'h0000_1000;
                endcase
                make_header(q, sig, off, wid, hgt, pln, dep, cmp);
                repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
            end else if (sel < 93) begin
                q.delete();
                repeat (HDR_LEN + $urandom_range(0, 10)) q.push_back(8'($urandom));
                if ($urandom_range(0, 1)) begin
                    q[0] = BMP_SIGNATURE[7:0];
                    q[1] = BMP_SIGNATURE[15:8];
                end
            end else begin
                q.delete();
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
            end
            if (q.size() != 0) begin
                send_file(q, 0);
                random_bytes += q.size();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        sb.errors += sb.decoded_q.size();
        $display("Sent %0d files (%0d bytes); checked %0d pixels and %0d/%0d/%0d/%0d statuses",
                 files_sent, sb.bytes_in, sb.pixels, sb.statuses[STATUS_OK],
                 sb.statuses[STATUS_BAD_SIG], sb.statuses[STATUS_BAD_FMT],
                 sb.statuses[STATUS_BAD_SIZE]);
        $display("(ok/signature/format/size) over %0d screen origins; %0d failures",
                 origins, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
